// ===== rtl/core/mtc_pkg.sv =====
// Shared types, character codes and the Morse code table of the text codec.
`timescale 1ns / 1ps
package mtc_pkg;

  // Request queue between the front and back ends
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CODE_COUNT  = 36;
  localparam int LETTER_COUNT = 26;

  // Input action codes
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // ASCII characters used by the codec
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // One Morse code: symbol count and dot/dash bits, dash = 1,
  // first symbol in the highest used bit.
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
  } morse_code_t;

  // Work handed from the front end to the back end. The back end emits
  // the enabled parts in this order: " / ", space, literal byte, code, done.
  typedef struct packed {
    logic       sep3;
    logic       sep1;
    logic       lit;
    logic [7:0] lit_char;
    logic       code;
    logic [5:0] code_idx;
    logic       done;
  } job_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    job_t head;
  } queue_head_t;

  function automatic morse_code_t code_entry(input logic [5:0] idx);
    morse_code_t c;
    case (idx)
      6'd0:  c = '{3'd2, 5'b00001};
      6'd1:  c = '{3'd4, 5'b01000};
      6'd2:  c = '{3'd4, 5'b01010};
      6'd3:  c = '{3'd3, 5'b00100};
      6'd4:  c = '{3'd1, 5'b00000};
      6'd5:  c = '{3'd4, 5'b00010};
      6'd6:  c = '{3'd3, 5'b00110};
      6'd7:  c = '{3'd4, 5'b00000};
      6'd8:  c = '{3'd2, 5'b00000};
      6'd9:  c = '{3'd4, 5'b00111};
      6'd10: c = '{3'd3, 5'b00101};
      6'd11: c = '{3'd4, 5'b00100};
      6'd12: c = '{3'd2, 5'b00011};
      6'd13: c = '{3'd2, 5'b00010};
      6'd14: c = '{3'd3, 5'b00111};
      6'd15: c = '{3'd4, 5'b00110};
      6'd16: c = '{3'd4, 5'b01101};
      6'd17: c = '{3'd3, 5'b00010};
      6'd18: c = '{3'd3, 5'b00000};
      6'd19: c = '{3'd1, 5'b00001};
      6'd20: c = '{3'd3, 5'b00001};
      6'd21: c = '{3'd4, 5'b00001};
      6'd22: c = '{3'd3, 5'b00011};
      6'd23: c = '{3'd4, 5'b01001};
      6'd24: c = '{3'd4, 5'b01011};
      6'd25: c = '{3'd4, 5'b01100};
      6'd26: c = '{3'd5, 5'b11111};
      6'd27: c = '{3'd5, 5'b01111};
      6'd28: c = '{3'd5, 5'b00111};
      6'd29: c = '{3'd5, 5'b00011};
      6'd30: c = '{3'd5, 5'b00001};
      6'd31: c = '{3'd5, 5'b00000};
      6'd32: c = '{3'd5, 5'b10000};
      6'd33: c = '{3'd5, 5'b11000};
      6'd34: c = '{3'd5, 5'b11100};
      6'd35: c = '{3'd5, 5'b11110};
      default: c = '{3'd0, 5'b00000};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] code_char(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx < 6'(LETTER_COUNT)) begin
      ch = CH_A + {2'b00, idx};
    end else begin
      ch = CH_ZERO + {2'b00, idx} - 8'(LETTER_COUNT);
    end
    return ch;
  endfunction

  // Character for a collected decode pattern, '?' when it matches nothing.
  function automatic logic [7:0] decode_letter(input logic       bad,
                                                input logic [2:0] count,
                                                input logic [4:0] pattern);
    logic [7:0]  ch;
    morse_code_t c;
    ch = CH_QMARK;
    if (!bad && count != 3'd0 && count <= 3'd5) begin
      for (int i = 0; i < CODE_COUNT; i++) begin
        c = code_entry(6'(i));
        if (c.len == count && c.bits == pattern) begin
          ch = code_char(6'(i));
        end
      end
    end
    return ch;
  endfunction

endpackage

// ===== rtl/core/mtc_if.sv =====
// Valid/ready channel interfaces for the text codec input and output.
`timescale 1ns / 1ps
interface morse_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface morse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_char, output char_valid,
                  output run_last, output text_done, input ready);
  modport sink   (input valid, input out_char, input char_valid,
                  input run_last, input text_done, output ready);
endinterface

// ===== rtl/core/mtc_front.sv =====
// Front end: accepts requests, tracks word and letter state, builds jobs.
`timescale 1ns / 1ps
module mtc_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  morse_in_if.sink     in_chan,
  input  logic         q_full,
  output logic         q_push,
  output mtc_pkg::job_t q_job
);
  import mtc_pkg::*;

  logic       dir_r, dir_nxt;
  logic       word_open_r, word_open_nxt;
  logic       any_word_r, any_word_nxt;
  logic       letter_r, letter_nxt;
  logic [4:0] pattern_r, pattern_nxt;
  logic [2:0] count_r, count_nxt;
  logic       bad_r, bad_nxt;
  logic       part_open_r, part_open_nxt;

  logic       in_fire;
  logic [7:0] c_in;
  logic [7:0] c_up;
  logic [7:0] flush_char;
  logic       letter_eff;
  job_t       job;

  assign in_chan.ready = !q_full;
  assign in_fire       = in_chan.valid && !q_full;
  assign c_in          = in_chan.char_in;
  assign c_up          = (c_in inside {[CH_LOW_A:CH_LOW_Z]}) ? c_in - CASE_OFFSET : c_in;
  assign flush_char    = decode_letter(bad_r, count_r, pattern_r);
  assign letter_eff    = word_open_r ? letter_r : 1'b0;

  always_comb begin
    dir_nxt       = dir_r;
    word_open_nxt = word_open_r;
    any_word_nxt  = any_word_r;
    letter_nxt    = letter_r;
    pattern_nxt   = pattern_r;
    count_nxt     = count_r;
    bad_nxt       = bad_r;
    part_open_nxt = part_open_r;
    job           = '0;

    if (in_fire) begin
      if (in_chan.action == ACT_END) begin
        if (dir_r == DIR_DECODE && part_open_r) begin
          job.lit      = 1'b1;
          job.lit_char = flush_char;
        end
        job.done      = 1'b1;
        word_open_nxt = 1'b0;
        any_word_nxt  = 1'b0;
        letter_nxt    = 1'b0;
        pattern_nxt   = '0;
        count_nxt     = '0;
        bad_nxt       = 1'b0;
        part_open_nxt = 1'b0;
      end else if (dir_r == DIR_DECODE) begin
        if (c_in == CH_SLASH) begin
          job.lit       = part_open_r;
          job.lit_char  = flush_char;
          part_open_nxt = 1'b0;
          pattern_nxt   = '0;
          count_nxt     = '0;
          bad_nxt       = 1'b0;
          word_open_nxt = 1'b0;
        end else begin
          if (!word_open_r) begin
            job.sep1      = any_word_r;
            any_word_nxt  = 1'b1;
            word_open_nxt = 1'b1;
          end
          if (c_in == CH_SPACE) begin
            job.lit       = part_open_r;
            job.lit_char  = flush_char;
            part_open_nxt = 1'b0;
            pattern_nxt   = '0;
            count_nxt     = '0;
            bad_nxt       = 1'b0;
          end else begin
            part_open_nxt = 1'b1;
            if (c_in == CH_DOT || c_in == CH_DASH) begin
              if (count_r < 3'd5) begin
                pattern_nxt = {pattern_r[3:0], c_in == CH_DASH};
              end
            end else begin
              bad_nxt = 1'b1;
            end
            if (count_r < 3'd6) begin
              count_nxt = count_r + 3'd1;
            end
          end
        end
      end else begin
        if (c_in == CH_SPACE) begin
          word_open_nxt = 1'b0;
        end else begin
          if (!word_open_r) begin
            job.sep3      = any_word_r;
            any_word_nxt  = 1'b1;
            word_open_nxt = 1'b1;
          end
          if (c_up inside {[CH_A:CH_Z]}) begin
            job.code     = 1'b1;
            job.code_idx = 6'(c_up - CH_A);
          end else if (c_up inside {[CH_ZERO:CH_NINE]}) begin
            job.code     = 1'b1;
            job.code_idx = 6'(c_up - CH_ZERO) + 6'(LETTER_COUNT);
          end
          if (job.code) begin
            job.sep1   = letter_eff;
            letter_nxt = 1'b1;
          end else begin
            letter_nxt = letter_eff;
          end
        end
      end
    end

    // A direction write restarts the stream
    if (cfg_we) begin
      dir_nxt       = cfg_wdata;
      word_open_nxt = 1'b0;
      any_word_nxt  = 1'b0;
      letter_nxt    = 1'b0;
      pattern_nxt   = '0;
      count_nxt     = '0;
      bad_nxt       = 1'b0;
      part_open_nxt = 1'b0;
    end
  end

  assign q_push = in_fire && (job.sep3 || job.sep1 || job.lit || job.code || job.done);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_ENCODE;
      word_open_r <= 1'b0;
      any_word_r  <= 1'b0;
      letter_r    <= 1'b0;
      pattern_r   <= '0;
      count_r     <= '0;
      bad_r       <= 1'b0;
      part_open_r <= 1'b0;
    end else begin
      dir_r       <= dir_nxt;
      word_open_r <= word_open_nxt;
      any_word_r  <= any_word_nxt;
      letter_r    <= letter_nxt;
      pattern_r   <= pattern_nxt;
      count_r     <= count_nxt;
      bad_r       <= bad_nxt;
      part_open_r <= part_open_nxt;
    end
  end

endmodule

// ===== rtl/core/mtc_queue.sv =====
// Small job queue between the front and back ends.
`timescale 1ns / 1ps
module mtc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtc_pkg::job_t       push_job,
  output logic                full,
  input  logic                pop,
  output mtc_pkg::queue_head_t head
);
  import mtc_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.empty = (count_r == '0);
  assign head.head  = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && !head.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/mtc_back.sv =====
// Back end: expands queued jobs into output bytes, one per cycle while out_chan is ready.
`timescale 1ns / 1ps
module mtc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtc_pkg::queue_head_t q_head,
  output logic                 q_pop,
  morse_out_if.source          out_chan
);
  import mtc_pkg::*;

  logic       valid_r, valid_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] char_r;
  logic       cvalid_r, last_r, done_r;

  job_t        h;
  morse_code_t code;
  logic [3:0]  o1, o2, o3, total;
  logic [3:0]  l3, lc;
  logic [2:0]  k, sidx;
  logic [7:0]  byte_out;
  logic        is_done, is_last, step;

  assign h    = q_head.head;
  assign code = code_entry(h.code_idx);
  assign l3   = h.sep3 ? 4'd3 : 4'd0;
  assign lc   = h.code ? {1'b0, code.len} : 4'd0;
  assign o1   = l3 + {3'b000, h.sep1};
  assign o2   = o1 + {3'b000, h.lit};
  assign o3   = o2 + lc;
  assign total = o3 + {3'b000, h.done};
  assign k    = 3'(pos_r - o2);
  assign sidx = 3'(code.len - 3'd1 - k);

  // Byte at the current position of the head job
  always_comb begin
    is_done = 1'b0;
    if (pos_r < l3) begin
      byte_out = (pos_r == 4'd1) ? CH_SLASH : CH_SPACE;
    end else if (pos_r < o1) begin
      byte_out = CH_SPACE;
    end else if (pos_r < o2) begin
      byte_out = h.lit_char;
    end else if (pos_r < o3) begin
      byte_out = code.bits[sidx] ? CH_DASH : CH_DOT;
    end else begin
      byte_out = CH_NUL;
      is_done  = 1'b1;
    end
  end

  assign is_last = (pos_r == total - 4'd1);
  assign step    = (!valid_r || out_chan.ready) && !q_head.empty;
  assign q_pop   = step && is_last;

  always_comb begin
    valid_nxt = valid_r;
    pos_nxt   = pos_r;
    if (!valid_r || out_chan.ready) begin
      valid_nxt = !q_head.empty;
    end
    if (step) begin
      pos_nxt = is_last ? 4'd0 : pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      char_r   <= byte_out;
      cvalid_r <= !is_done;
      last_r   <= is_last;
      done_r   <= is_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.out_char   = char_r;
  assign out_chan.char_valid = cvalid_r;
  assign out_chan.run_last   = last_r;
  assign out_chan.text_done  = done_r;

endmodule

// ===== rtl/core/morse_text_codec.sv =====
// Top level of the streaming Morse text encoder and decoder.
//
//   Channel   Dir   Handshake          Contents
//   in_chan   in    valid / ready      action, char_in
//   out_chan  out   valid / ready      out_char, char_valid, run_last, text_done
//   cfg_*     in    cfg_we (no wait)   cfg_wdata = direction
//
// A request is taken whenever the job queue has room; the front end never
// waits on the output side beyond that queue. Each request yields 0 to 8
// output bytes and the back end sends one byte per cycle while out_chan is
// ready; the output byte rate sets the pace. Reset is synchronous and
// active low; it clears the stream state, the queue and the output valid
// flag. A stall on out_chan holds the output register and fills the queue
// before in_chan.ready drops.
`timescale 1ns / 1ps
module morse_text_codec (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  morse_in_if.sink     in_chan,
  morse_out_if.source  out_chan
);
  import mtc_pkg::*;

  job_t        push_job;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  queue_head_t q_head;

  // Front end: decides per request which separators, letters and marker
  // are due, and keeps the word and letter state of the stream.
  mtc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Jobs wait here so the two ends can stall independently.
  mtc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Back end: walks each job byte by byte into the output register.
  mtc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== tb/sv/morse_text_codec_test.sv =====
// Self-checking testbench for the streaming Morse text encoder/decoder.
`timescale 1ns / 1ps
module morse_text_codec_test;
  import mtc_pkg::*;

  // Cycles allowed after the last expected byte. The job queue is four deep;
  // a request that makes no bytes is never queued.
  localparam int SETTLE_CYCLES = 16;
  // Length of the one long receiver hold-off, long enough to fill the queue.
  localparam int HOLD_CYCLES   = 200;

  // One output byte as the block presents it on out_chan.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_char;
    logic       last;
    logic       done;
  } codec_byte_t;

  // Mirror of the codec stream state. It turns every accepted request into
  // the bytes the block must send, keeps them in order and checks each byte
  // that comes out against the oldest one.
  class morse_codec_mirror;
    string symbols[36] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
      "---..", "----."};

    logic        direction;
    logic        word_open;
    logic        any_word_seen;
    logic        letter_in_word;
    logic        part_open;
    logic        sym_bad;
    logic [4:0]  sym_bits;
    logic [2:0]  sym_count;
    codec_byte_t expected_bytes[$];
    codec_byte_t burst[$];
    int          errors;

    function new();
      direction = DIR_ENCODE;
      errors    = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      word_open      = 1'b0;
      any_word_seen  = 1'b0;
      letter_in_word = 1'b0;
      part_open      = 1'b0;
      sym_bad        = 1'b0;
      sym_bits       = '0;
      sym_count      = '0;
    endfunction

    // A register write also drops whatever the stream was holding.
    function void write_direction(logic v);
      direction = v;
      clear_stream();
    endfunction

    function void emit(logic [7:0] ch, logic done);
      codec_byte_t b;
      b.ch      = ch;
      b.is_char = !done;
      b.last    = 1'b0;
      b.done    = done;
      burst.push_back(b);
    endfunction

    function void emit_code(int idx);
      string s;
      s = symbols[idx];
      for (int i = 0; i < s.len(); i++) emit(s[i], 1'b0);
    endfunction

    function logic [7:0] letter_for_pattern();
      logic [7:0] ch;
      logic [4:0] bits;
      string      s;
      ch = CH_QMARK;
      if (sym_bad || sym_count == 3'd0 || sym_count > 3'd5) return ch;
      for (int i = 0; i < 36; i++) begin
        s    = symbols[i];
        bits = '0;
        for (int j = 0; j < s.len(); j++) bits = {bits[3:0], s[j] == CH_DASH};
        if (s.len() == sym_count && bits == sym_bits) begin
          ch = (i < 26) ? CH_A + 8'(i) : CH_ZERO + 8'(i - 26);
        end
      end
      return ch;
    endfunction

    function void flush_part();
      if (part_open) emit(letter_for_pattern(), 1'b0);
      part_open = 1'b0;
      sym_bad   = 1'b0;
      sym_bits  = '0;
      sym_count = '0;
    endfunction

    function void encode_char(logic [7:0] ch);
      int idx;
      idx = -1;
      if (ch == CH_SPACE) begin
        word_open = 1'b0;
        return;
      end
      if (ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CASE_OFFSET;
      // The word separator goes out only when the next word really starts.
      if (!word_open) begin
        if (any_word_seen) begin
          emit(CH_SPACE, 1'b0);
          emit(CH_SLASH, 1'b0);
          emit(CH_SPACE, 1'b0);
        end
        any_word_seen  = 1'b1;
        word_open      = 1'b1;
        letter_in_word = 1'b0;
      end
      if (ch >= CH_A && ch <= CH_Z) begin
        idx = int'(ch - CH_A);
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        idx = 26 + int'(ch - CH_ZERO);
      end
      if (idx >= 0) begin
        if (letter_in_word) emit(CH_SPACE, 1'b0);
        emit_code(idx);
        letter_in_word = 1'b1;
      end
    endfunction

    function void decode_char(logic [7:0] ch);
      if (ch == CH_SLASH) begin
        flush_part();
        word_open = 1'b0;
        return;
      end
      if (!word_open) begin
        if (any_word_seen) emit(CH_SPACE, 1'b0);
        any_word_seen = 1'b1;
        word_open     = 1'b1;
      end
      if (ch == CH_SPACE) begin
        flush_part();
        return;
      end
      part_open = 1'b1;
      if (ch == CH_DOT || ch == CH_DASH) begin
        if (sym_count < 3'd5) sym_bits = {sym_bits[3:0], ch == CH_DASH};
      end else begin
        sym_bad = 1'b1;
      end
      if (sym_count < 3'd6) sym_count = sym_count + 3'd1;
    endfunction

    function void take_request(logic act, logic [7:0] ch);
      burst.delete();
      if (act == ACT_END) begin
        if (direction == DIR_DECODE) flush_part();
        emit(CH_NUL, 1'b1);
        clear_stream();
      end else if (direction == DIR_DECODE) begin
        decode_char(ch);
      end else begin
        encode_char(ch);
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_byte(codec_byte_t got);
      codec_byte_t want;
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected output: char %02h valid %0b last %0b done %0b",
                               got.ch, got.is_char, got.last, got.done));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.ch !== want.ch || got.is_char !== want.is_char ||
          got.last !== want.last || got.done !== want.done) begin
        note_failure($sformatf({"output mismatch: expected char %02h valid %0b last %0b",
                                " done %0b, got char %02h valid %0b last %0b done %0b"},
                               want.ch, want.is_char, want.last, want.done,
                               got.ch, got.is_char, got.last, got.done));
      end
    endfunction

    function void check_drained();
      codec_byte_t want;
      while (expected_bytes.size() > 0) begin
        want = expected_bytes.pop_front();
        note_failure($sformatf("missing output: char %02h valid %0b last %0b done %0b",
                               want.ch, want.is_char, want.last, want.done));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  morse_in_if  in_bus();
  morse_out_if out_bus();

  morse_text_codec DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  morse_codec_mirror codec;

  int n_requests = 0;
  int n_ends     = 0;
  int n_bytes    = 0;
  int n_cfg      = 0;
  // Set by the sender side to ask the receiver for its long hold-off.
  bit hold_arm   = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Hard stop in case the block hangs. The slowest correct run is far below
  // this even with every request making eight bytes and every byte stalled.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Sender idle length: mostly none or short, a few long ones. Every fourth
  // block of 32 requests goes out back to back.
  function automatic int send_gap();
    int r;
    if (((n_requests / 32) % 4) == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Offer one request and wait until the block takes it. Inputs only change
  // at the falling edge, and valid is never dropped and raised in one step.
  task automatic send_req(input logic act, input logic [7:0] ch);
    int gap;
    gap = send_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.char_in <= ch;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    codec.take_request(act, ch);
    n_requests++;
    if (act == ACT_END) n_ends++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(ACT_CHAR, s[i]);
  endtask

  // Stop offering and wait for every expected byte plus a settle time.
  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (codec.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_direction(input logic v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    codec.write_direction(v);
    n_cfg++;
  endtask

  function automatic logic [7:0] random_alnum();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CH_LOW_A + 8'($urandom_range(0, 25));
    if (r < 80) return CH_A + 8'($urandom_range(0, 25));
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // A byte that is not part of clean text: anything at all, or one of the
  // characters that carry meaning to the decoder.
  function automatic logic [7:0] random_noise();
    case ($urandom_range(0, 7))
      0: return CH_SLASH;
      1: return CH_DOT;
      2: return CH_DASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random text for the encoder: mostly words of letters and digits in mixed
  // case with space separators, sometimes stray bytes inside or between the
  // words, and now and then an end of text. The long receiver hold-off is
  // requested once hold_at requests of the phase have gone out.
  task automatic encode_phase(input int count, input int hold_at);
    int base;
    int len;
    int r;
    base = n_requests;
    while (n_requests - base < count) begin
      if (hold_at >= 0 && n_requests - base >= hold_at) begin
        hold_arm = 1'b1;
        hold_at  = -1;
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 8) send_req(ACT_CHAR, random_noise());
          send_req(ACT_CHAR, random_alnum());
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_req(ACT_END, 8'($urandom_range(0, 255)));
        end else begin
          send_req(ACT_CHAR, CH_SPACE);
          if (r > 85) send_req(ACT_CHAR, CH_SPACE);
        end
      end else begin
        send_req(ACT_CHAR, random_noise());
      end
    end
  endtask

  // Random Morse for the decoder: mostly words of valid codes split by
  // spaces and ended by slashes, with some broken letters (too long, or with
  // a foreign byte in them). Once pause_at requests have gone out the sender
  // waits until the block has caught up completely.
  task automatic decode_phase(input int count, input int pause_at);
    int    base;
    int    letters;
    int    len;
    int    r;
    string s;
    base = n_requests;
    while (n_requests - base < count) begin
      if (pause_at >= 0 && n_requests - base >= pause_at) begin
        wait_idle();
        pause_at = -1;
      end
      letters = $urandom_range(1, 4);
      for (int i = 0; i < letters; i++) begin
        if (i > 0) begin
          send_req(ACT_CHAR, CH_SPACE);
          if ($urandom_range(0, 99) < 10) send_req(ACT_CHAR, CH_SPACE);
        end
        if ($urandom_range(0, 99) < 12) begin
          len = $urandom_range(1, 7);
          for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 99) < 15) begin
              send_req(ACT_CHAR, 8'($urandom_range(0, 255)));
            end else begin
              send_req(ACT_CHAR, $urandom_range(0, 1) ? CH_DASH : CH_DOT);
            end
          end
        end else begin
          s = codec.symbols[$urandom_range(0, 35)];
          send_text(s);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_text(" / ");
      end else if (r < 75) begin
        send_req(ACT_CHAR, CH_SLASH);
      end else if (r < 90) begin
        send_req(ACT_CHAR, CH_SPACE);
      end else begin
        send_req(ACT_END, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: samples each output byte at the rising edge and moves ready at
  // the falling edge. Stalls are random, mostly short, and every fourth block
  // of 64 bytes is taken without any stall. On request it holds ready low for
  // one long stretch, counted here, so the queue fills and in_chan stalls.
  initial begin : result_drain
    codec_byte_t got;
    int          stall_left;
    int          r;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.ch      = out_bus.out_char;
        got.is_char = out_bus.char_valid;
        got.last    = out_bus.run_last;
        got.done    = out_bus.text_done;
        codec.check_byte(got);
        n_bytes++;
      end
      @(negedge clk);
      if (hold_arm) begin
        hold_arm   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (((n_bytes / 64) % 4) != 1 && $urandom_range(0, 99) < 18) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          stall_left = $urandom_range(1, 3) - 1;
        end else if (r < 95) begin
          stall_left = $urandom_range(4, 10) - 1;
        end else begin
          stall_left = $urandom_range(15, 40) - 1;
        end
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    codec          = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = DIR_ENCODE;
    in_bus.valid   = 1'b0;
    in_bus.action  = ACT_CHAR;
    in_bus.char_in = CH_NUL;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Encoder straight out of reset. End of text with nothing pending gives
    // the done marker alone. Then a lower-case and an upper-case letter in
    // one word, a double space, a word holding only an unmapped byte and a
    // digit word, which must still be preceded by the separator, and an end
    // of text whose data byte is junk.
    send_req(ACT_END, CH_NUL);
    send_text("aZ  ");
    send_req(ACT_CHAR, CH_NUL);
    send_text(" 9");
    send_req(ACT_END, 8'hFF);
    wait_idle();

    // Decoder. A leading slash is an empty word and is skipped, Q is closed
    // by a slash, a letter with a foreign byte becomes a question mark, and
    // a six-symbol letter left open is flushed as a question mark by the end
    // of text. The dangling K at the end is thrown away by the next write.
    set_direction(DIR_DECODE);
    send_text("/--.-/.");
    send_req(ACT_CHAR, 8'hFF);
    send_text(" ------");
    send_req(ACT_END, CH_Z);
    send_text("-.-");
    wait_idle();

    // Rewriting the same direction clears the pending letter, so the end of
    // text must give only the done marker.
    set_direction(DIR_DECODE);
    send_req(ACT_END, 8'hFF);
    wait_idle();

    // Random phases, switching direction between them. The first one also
    // carries the long receiver hold-off, the second a full sender pause.
    set_direction(DIR_ENCODE);
    encode_phase(140, 40);
    wait_idle();
    set_direction(DIR_DECODE);
    decode_phase(140, 70);
    wait_idle();
    set_direction(DIR_ENCODE);
    encode_phase(60, -1);
    wait_idle();
    set_direction(DIR_DECODE);
    decode_phase(60, -1);
    wait_idle();

    codec.check_drained();
    $display("Covered %0d requests (%0d end of text) and %0d output bytes", n_requests,
             n_ends, n_bytes);
    $display("over %0d direction writes, with random stalls on both channels.", n_cfg);
    if (codec.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mtc_pkg.sv
rtl/core/mtc_if.sv
rtl/core/mtc_front.sv
rtl/core/mtc_queue.sv
rtl/core/mtc_back.sv
rtl/core/morse_text_codec.sv
tb/sv/morse_text_codec_test.sv
